// File: hw/rtl/ternary_triangle_histogram_assert.svh
// Assertion macros for the ternary triangle histogram.
`ifndef TERNARY_TRIANGLE_HISTOGRAM_ASSERT_SVH
`define TERNARY_TRIANGLE_HISTOGRAM_ASSERT_SVH
`ifndef SYNTHESIS
`define TTH_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define TTH_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define TTH_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define TTH_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

// File: hw/rtl/tth_pkg.sv
// Shared types and constants for the ternary triangle histogram.
package tth_pkg;
    localparam int MAX_SIDE    = 16;
    localparam int COUNT_WIDTH = 32;
    localparam int DEPTH       = MAX_SIDE * MAX_SIDE;
    localparam int AW          = $clog2(DEPTH);
    localparam int SW          = 5;
    localparam int QDEPTH      = 2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZERO = 2'd1;
    localparam logic [1:0] ST_OOR  = 2'd2;

    localparam logic CMD_FILL = 1'b0;
    localparam logic CMD_READ = 1'b1;

    typedef struct packed {
        logic        cmd;
        logic [15:0] part_a;
        logic [15:0] part_b;
        logic [15:0] part_c;
        logic [15:0] weight;
        logic [3:0]  read_row;
        logic [4:0]  read_slot;
    } t_in;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  bin_row;
        logic [4:0]  bin_slot;
        logic [31:0] bin_count;
    } t_out;

    // Classified job passed from the front to the back.
    typedef struct packed {
        logic        write;
        logic        skip;
        logic [1:0]  status;
        logic [3:0]  row;
        logic [4:0]  slot;
        logic [AW-1:0] addr;
        logic [15:0] weight;
    } t_job;
endpackage

// File: hw/rtl/tth_stream_if.sv
// Valid/ready channel interfaces for input and result beats.
interface tth_in_if;
    logic          valid;
    logic          ready;
    tth_pkg::t_in  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface tth_out_if;
    logic          valid;
    logic          ready;
    tth_pkg::t_out data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: hw/rtl/tth_front.sv
// Front end: bit-serial division that classifies each beat into a bin job.
module tth_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [4:0]        i_side,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  tth_pkg::t_in      i_in,
    output logic              o_job_valid,
    input  logic              i_job_ready,
    output tth_pkg::t_job     o_job
);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_FIX  = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0]  r_state, n_state;
    logic [4:0]  r_n;
    logic [17:0] r_s;
    logic [20:0] r_remb, r_rema;
    logic [4:0]  r_qb, r_qa;
    logic [2:0]  r_bit;
    logic [20:0] r_lhs;
    tth_pkg::t_job r_job;

    logic [4:0]  w_n;
    logic [17:0] w_sum;
    logic [22:0] w_tb, w_ta;
    logic [4:0]  w_row, w_last, w_slot;
    logic [5:0]  w_col2;
    logic [4:0]  w_cl;
    logic [23:0] w_rhs;
    logic [8:0]  w_base;

    assign w_n = (i_side == 5'd0) ? 5'd1 :
                 (i_side > 5'(tth_pkg::MAX_SIDE)) ? 5'(tth_pkg::MAX_SIDE) : i_side;
    assign w_sum = 18'(i_in.part_a) + 18'(i_in.part_b) + 18'(i_in.part_c);

    // One quotient bit per cycle for each of row and column.
    always_comb begin
        w_ta = 23'(r_s) << r_bit;
        w_tb = 23'(r_s) << r_bit;
    end

    always_comb begin
        w_row  = (r_qb > r_n - 5'd1) ? r_n - 5'd1 : r_qb;
        w_cl   = r_qb + r_qa + 5'd1;
        w_rhs  = 24'(r_s) * 24'(w_cl);
        w_col2 = {r_qa, 1'b0} | 6'(24'(r_lhs) > w_rhs);
        w_last = 5'((r_n - 5'd1 - w_row) << 1);
        w_slot = (w_col2 > 6'(w_last)) ? w_last : w_col2[4:0];
        w_base = 9'(w_row) * (9'({r_n, 1'b0}) - 9'(w_row));
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_in_valid) n_state = S_DIV;
            S_DIV:  if (r_bit == 3'd0) n_state = S_FIX;
            S_FIX:  n_state = S_OUT;
            S_OUT:  if (i_job_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_n    <= w_n;
                r_s    <= w_sum;
                r_lhs  <= 21'(w_n) * (21'(i_in.part_a) + 21'(i_in.part_b));
                r_remb <= 21'(w_n) * 21'(i_in.part_b);
                r_rema <= 21'(w_n) * 21'(i_in.part_a);
                r_qb   <= '0;
                r_qa   <= '0;
                r_bit  <= 3'd4;
                r_job.write  <= 1'b0;
                r_job.skip   <= 1'b0;
                r_job.status <= tth_pkg::ST_OK;
                r_job.row    <= i_in.read_row;
                r_job.slot   <= i_in.read_slot;
                r_job.weight <= i_in.weight;
                r_job.addr   <= '0;
                if (i_in.cmd == tth_pkg::CMD_READ) begin
                    if ({1'b0, i_in.read_row} >= w_n ||
                        i_in.read_slot > 5'((w_n - 5'd1 - {1'b0, i_in.read_row}) << 1)) begin
                        r_job.status <= tth_pkg::ST_OOR;
                        r_job.skip   <= 1'b1;
                    end
                end else if (w_sum == 18'd0) begin
                    r_job.status <= tth_pkg::ST_ZERO;
                    r_job.skip   <= 1'b1;
                    r_job.row    <= '0;
                    r_job.slot   <= '0;
                end else begin
                    r_job.write <= 1'b1;
                end
            end
            S_DIV: begin
                if (23'(r_rema) >= w_ta) begin
                    r_rema <= 21'(23'(r_rema) - w_ta);
                    r_qa   <= r_qa | (5'd1 << r_bit);
                end
                if (23'(r_remb) >= w_tb) begin
                    r_remb <= 21'(23'(r_remb) - w_tb);
                    r_qb   <= r_qb | (5'd1 << r_bit);
                end
                r_bit <= r_bit - 3'd1;
            end
            S_FIX: begin
                if (r_job.write) begin
                    r_job.row  <= w_row[3:0];
                    r_job.slot <= w_slot;
                    r_job.addr <= tth_pkg::AW'(w_base + 9'(w_slot));
                end else if (!r_job.skip) begin
                    r_job.addr <= tth_pkg::AW'(9'(r_job.row) *
                        (9'({r_n, 1'b0}) - 9'(r_job.row)) + 9'(r_job.slot));
                end
            end
            default: ;
        endcase
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_job_valid = (r_state == S_OUT);
    assign o_job       = r_job;
endmodule

// File: hw/rtl/tth_queue.sv
// Two-entry job queue between front and back.
module tth_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr_valid,
    output logic          o_wr_ready,
    input  tth_pkg::t_job i_wr,
    output logic          o_rd_valid,
    input  logic          i_rd_ready,
    output tth_pkg::t_job o_rd
);
    tth_pkg::t_job r_mem [tth_pkg::QDEPTH];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    logic w_push, w_pop;

    assign o_wr_ready = (r_cnt != 2'(tth_pkg::QDEPTH));
    assign o_rd_valid = (r_cnt != 2'd0);
    assign w_push = i_wr_valid && o_wr_ready;
    assign w_pop  = o_rd_valid && i_rd_ready;
    assign o_rd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_wr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end
endmodule

// File: hw/rtl/tth_back.sv
// Back end: bin memory read-modify-write with clearing pass and result register.
module tth_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_job_valid,
    output logic              o_job_ready,
    input  tth_pkg::t_job     i_job,
    output logic              o_clearing,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output tth_pkg::t_out     o_out
);
    localparam logic [1:0] S_CLR  = 2'd0;
    localparam logic [1:0] S_IDLE = 2'd1;
    localparam logic [1:0] S_RD   = 2'd2;
    localparam logic [1:0] S_WR   = 2'd3;
    localparam logic [tth_pkg::COUNT_WIDTH-1:0] CMAX = '1;

    logic [tth_pkg::COUNT_WIDTH-1:0] r_mem [tth_pkg::DEPTH];
    logic [tth_pkg::COUNT_WIDTH-1:0] r_rdata;
    logic [1:0]  r_state;
    logic [tth_pkg::AW:0] r_clr;
    tth_pkg::t_job r_job;
    logic r_ovalid;
    tth_pkg::t_out r_out;
    logic [tth_pkg::COUNT_WIDTH-1:0] w_sum;
    logic w_we;
    logic [tth_pkg::AW-1:0] w_waddr;
    logic [tth_pkg::COUNT_WIDTH-1:0] w_wdata;
    logic w_take;

    assign w_take = (r_state == S_IDLE) && i_job_valid && !r_ovalid;
    assign o_job_ready = w_take;
    assign w_sum = ((CMAX - r_rdata) < tth_pkg::COUNT_WIDTH'(r_job.weight)) ? CMAX :
                   r_rdata + tth_pkg::COUNT_WIDTH'(r_job.weight);
    assign w_we    = (r_state == S_CLR) || (r_state == S_WR && r_job.write);
    assign w_waddr = (r_state == S_CLR) ? r_clr[tth_pkg::AW-1:0] : r_job.addr;
    assign w_wdata = (r_state == S_CLR) ? '0 : w_sum;

    // The bin is read once, at the edge that takes the job, and held until the update.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (w_take) begin
            r_rdata <= r_mem[i_job.addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && i_out_ready) r_ovalid <= 1'b0;
            case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr[tth_pkg::AW-1:0] == '1) r_state <= S_IDLE;
                end
                S_IDLE: if (w_take) r_state <= S_RD;
                S_RD:   r_state <= S_WR;
                S_WR: begin
                    r_ovalid <= 1'b1;
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) r_job <= i_job;
        if (r_state == S_WR) begin
            r_out.status  <= r_job.status;
            r_out.bin_row <= r_job.row;
            r_out.bin_slot <= r_job.slot;
            r_out.bin_count <= r_job.skip ? 32'd0 :
                (r_job.write ? 32'(w_sum) : 32'(r_rdata));
        end
    end

    assign o_clearing  = (r_state == S_CLR);
    assign o_out_valid = r_ovalid;
    assign o_out       = r_out;
endmodule

// File: hw/rtl/ternary_triangle_histogram.sv
// Top level of the ternary triangle histogram.
// Usage:
// Input beats arrive on i_in (valid/ready). cmd 0 fills a composition
// (part_a, part_b, part_c) with weight; cmd 1 reads bin (read_row, read_slot).
// Every input beat gives one result beat on o_out: status, bin_row,
// bin_slot and bin_count.
// bins_per_side is to be written through i_cfg_we/i_cfg_data only while
// the block idles; the block itself does not enforce this. The front runs
// a bit-serial quotient loop for row and column, then bin placement and
// handoff, and takes a new beat only after its job is handed off. The
// back does a memory read, an update and a result register write per
// beat, and takes no next job while a result waits in the output
// register. The front's loop sets the throughput. After reset the back
// clears all 256 bins, one per cycle; input beats still enter the front
// and wait in the job queue during that time.
// When the receiver stalls, one result waits in the output register, the
// queue fills, and the front then holds its input ready low.
module ternary_triangle_histogram (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [4:0] i_cfg_data,
    tth_in_if.sink     i_in,
    tth_out_if.source  o_out
);
    logic [4:0] r_side;
    logic w_jv, w_jr, w_qv, w_qr, w_clr;
    tth_pkg::t_job w_job, w_qjob;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side <= 5'd16;
        end else if (i_cfg_we) begin
            r_side <= i_cfg_data;
        end
    end

    tth_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_side(r_side),
        .i_in_valid(i_in.valid), .o_in_ready(i_in.ready), .i_in(i_in.data),
        .o_job_valid(w_jv), .i_job_ready(w_jr), .o_job(w_job)
    );

    tth_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_wr_valid(w_jv), .o_wr_ready(w_jr), .i_wr(w_job),
        .o_rd_valid(w_qv), .i_rd_ready(w_qr), .o_rd(w_qjob)
    );

    tth_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_job_valid(w_qv), .o_job_ready(w_qr), .i_job(w_qjob),
        .o_clearing(w_clr),
        .o_out_valid(o_out.valid), .i_out_ready(o_out.ready), .o_out(o_out.data)
    );

`include "ternary_triangle_histogram_assert.svh"

    `TTH_ASSERT_NEVER(a_no_take_clr, i_clk, i_rst_n, w_clr && w_qr, "job taken during clear")
    `TTH_ASSERT_IMPL(a_fill_ok, i_clk, i_rst_n, (o_out.valid && o_out.data.status == tth_pkg::ST_ZERO) |-> (o_out.data.bin_count == 32'd0), "zero-sum fill has nonzero count")
    `TTH_ASSERT_NEVER(a_status_code, i_clk, i_rst_n, o_out.valid && o_out.data.status == 2'd3, "undefined status")
endmodule

// File: tb/ternary_triangle_histogram_tb.sv
// Self-checking testbench for the ternary triangle histogram: directed table, a side-1 fill run, then random beats.
`timescale 1ns / 100ps
module ternary_triangle_histogram_tb;
    localparam int LIMIT_CYCLES = 1_000_000;
    localparam int N_RANDOM     = 2000;
    localparam int DRAIN_CYCLES = 40;
    localparam int N_DIRECTED   = 15;

    typedef struct {
        tth_pkg::t_in  beat;
        bit            known;
        tth_pkg::t_out result;
    } t_row;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_we = 1'b0;
    logic [4:0] i_cfg_data = '0;

    tth_in_if  in_ch ();
    tth_out_if out_ch ();

    ternary_triangle_histogram u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch.sink),
        .o_out      (out_ch.source)
    );

    always #4 i_clk = ~i_clk;

    // Predictor state: its own copy of the bins and the side register.
    logic [31:0]   hist_bins [tth_pkg::DEPTH];
    logic [4:0]    side_reg;
    tth_pkg::t_out expected_q [$];
    t_row          directed_rows [N_DIRECTED];

    int cycle_count = 0;
    int mismatches  = 0;
    int results_seen = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit hold_receiver = 1'b0;
    int fills_sent = 0;
    int reads_sent = 0;

    function automatic tth_pkg::t_out predict_histogram(tth_pkg::t_in b);
        tth_pkg::t_out r;
        logic [63:0]   n, s, row, col, slot, last, addr, v;
        r = '0;
        n = 64'(side_reg);
        if (n == 64'd0) n = 64'd1;
        if (n > 64'(tth_pkg::MAX_SIDE)) n = 64'(tth_pkg::MAX_SIDE);
        if (b.cmd == tth_pkg::CMD_FILL) begin
            s = 64'(b.part_a) + 64'(b.part_b) + 64'(b.part_c);
            if (s == 64'd0) begin
                r.status = tth_pkg::ST_ZERO;
            end else begin
                row = (n * 64'(b.part_b)) / s;
                col = (n * 64'(b.part_a)) / s;
                slot = 64'd2 * col;
                if (n * (64'(b.part_a) + 64'(b.part_b)) > s * (row + col + 64'd1))
                    slot = slot + 64'd1;
                if (row > n - 64'd1) row = n - 64'd1;
                last = 64'd2 * (n - 64'd1 - row);
                if (slot > last) slot = last;
                addr = (row * (64'd2 * n - row) + slot) % 64'(tth_pkg::DEPTH);
                v = 64'(hist_bins[addr[tth_pkg::AW-1:0]]) + 64'(b.weight);
                if (v > 64'hFFFF_FFFF) v = 64'hFFFF_FFFF;
                hist_bins[addr[tth_pkg::AW-1:0]] = v[31:0];
                r.status = tth_pkg::ST_OK;
                r.bin_row = row[3:0];
                r.bin_slot = slot[4:0];
                r.bin_count = v[31:0];
            end
        end else begin
            r.bin_row = b.read_row;
            r.bin_slot = b.read_slot;
            row = 64'(b.read_row);
            slot = 64'(b.read_slot);
            if (row >= n || slot > 64'd2 * (n - 64'd1 - row)) begin
                r.status = tth_pkg::ST_OOR;
            end else begin
                addr = (row * (64'd2 * n - row) + slot) % 64'(tth_pkg::DEPTH);
                r.status = tth_pkg::ST_OK;
                r.bin_count = hist_bins[addr[tth_pkg::AW-1:0]];
            end
        end
        return r;
    endfunction

    // Result checker and cycle limit.
    always @(posedge i_clk) begin
        tth_pkg::t_out got, want;
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("RESULT: ERROR");
            $finish;
        end
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = out_ch.data;
            results_seen <= results_seen + 1;
            if (expected_q.size() == 0) begin
                mismatches <= mismatches + 1;
                if (mismatches < 10) $display("unexpected result beat %p", got);
            end else begin
                want = expected_q.pop_front();
                if (got !== want) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("mismatch: expected %p, got %p", want, got);
                end
            end
        end
    end

    // Receiver: random stalls plus an optional long hold-off.
    always @(negedge i_clk) begin
        if (hold_receiver) out_ch.ready <= 1'b0;
        else out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Valid stays high after a beat until the next one or an idle cycle replaces it.
    task automatic send_beat(tth_pkg::t_in b, bit known, tth_pkg::t_out given);
        tth_pkg::t_out p;
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= b;
        do @(posedge i_clk); while (!in_ch.ready);
        p = predict_histogram(b);
        if (known) p = given;
        expected_q = {expected_q, p};
        if (b.cmd == tth_pkg::CMD_FILL) fills_sent++; else reads_sent++;
        @(negedge i_clk);
    endtask

    task automatic wait_results();
        in_ch.valid <= 1'b0;
        while (expected_q.size() != 0) @(negedge i_clk);
    endtask

    task automatic wait_drained();
        wait_results();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_side(logic [4:0] v);
        wait_drained();
        i_cfg_we <= 1'b1;
        i_cfg_data <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        side_reg = v;
    endtask

    function automatic tth_pkg::t_in fill_beat(int a, int b, int c, int w);
        tth_pkg::t_in x;
        x = '0;
        x.cmd = tth_pkg::CMD_FILL;
        x.part_a = 16'(a); x.part_b = 16'(b); x.part_c = 16'(c); x.weight = 16'(w);
        return x;
    endfunction

    function automatic tth_pkg::t_in read_beat(int r, int s);
        tth_pkg::t_in x;
        x = '0;
        x.cmd = tth_pkg::CMD_READ;
        x.read_row = 4'(r); x.read_slot = 5'(s);
        return x;
    endfunction

    function automatic t_row mk_row(tth_pkg::t_in b, bit known, int st, int r, int s,
                                    longint cnt);
        t_row x;
        x.beat = b;
        x.known = known;
        x.result.status = 2'(st);
        x.result.bin_row = 4'(r);
        x.result.bin_slot = 5'(s);
        x.result.bin_count = 32'(cnt);
        return x;
    endfunction

    function automatic tth_pkg::t_in random_beat();
        tth_pkg::t_in x;
        int           n, sel;
        x.cmd = 1'($urandom);
        x.part_a = 16'($urandom);
        x.part_b = 16'($urandom);
        x.part_c = 16'($urandom);
        x.weight = 16'($urandom);
        x.read_row = 4'($urandom);
        x.read_slot = 5'($urandom);
        n = int'(side_reg);
        if (n == 0) n = 1;
        if (n > tth_pkg::MAX_SIDE) n = tth_pkg::MAX_SIDE;
        sel = int'($urandom_range(9));
        // Mostly fills with varied magnitudes; some reads aimed inside the triangle.
        if (sel < 6) begin
            x.cmd = tth_pkg::CMD_FILL;
            if ($urandom_range(3) == 0) begin
                x.part_a = 16'($urandom_range(4)); x.part_b = 16'($urandom_range(4));
                x.part_c = 16'($urandom_range(4));
            end
            if ($urandom_range(7) == 0) x.weight = 16'hFFFF;
        end else begin
            x.cmd = tth_pkg::CMD_READ;
            if (sel < 9) begin
                x.read_row = 4'($urandom_range(n - 1));
                x.read_slot = 5'($urandom_range(2 * (n - 1 - int'(x.read_row))));
            end
        end
        return x;
    endfunction

    initial begin
        logic [4:0] sides [6];
        int k;
        sides = '{5'd1, 5'd0, 5'd31, 5'd3, 5'd7, 5'd16};
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
        side_reg = 5'd16;
        foreach (hist_bins[i]) hist_bins[i] = '0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table at reset side 16.
        directed_rows[0]  = mk_row(read_beat(0, 0), 1'b1, tth_pkg::ST_OK, 0, 0, 0);
        directed_rows[1]  = mk_row(read_beat(15, 0), 1'b1, tth_pkg::ST_OK, 15, 0, 0);
        directed_rows[2]  = mk_row(read_beat(15, 1), 1'b1, tth_pkg::ST_OOR, 15, 1, 0);
        directed_rows[3]  = mk_row(read_beat(0, 31), 1'b1, tth_pkg::ST_OOR, 0, 31, 0);
        directed_rows[4]  = mk_row(read_beat(0, 30), 1'b1, tth_pkg::ST_OK, 0, 30, 0);
        directed_rows[5]  = mk_row(fill_beat(0, 0, 0, 5), 1'b1, tth_pkg::ST_ZERO, 0, 0, 0);
        directed_rows[6]  = mk_row(fill_beat(0, 0, 1, 7), 1'b1, tth_pkg::ST_OK, 0, 0, 7);
        directed_rows[7]  = mk_row(fill_beat(0, 65535, 0, 65535), 1'b1, tth_pkg::ST_OK,
                                   15, 0, 65535);
        directed_rows[8]  = mk_row(fill_beat(65535, 0, 0, 1), 1'b1, tth_pkg::ST_OK, 0, 30, 1);
        directed_rows[9]  = mk_row(fill_beat(65535, 65535, 65535, 65535), 1'b0, 0, 0, 0, 0);
        directed_rows[10] = mk_row(fill_beat(1, 1, 1, 0), 1'b0, 0, 0, 0, 0);
        directed_rows[11] = mk_row(fill_beat(3, 1, 0, 9), 1'b0, 0, 0, 0, 0);
        directed_rows[12] = mk_row(fill_beat(2, 1, 1, 4), 1'b0, 0, 0, 0, 0);
        directed_rows[13] = mk_row(read_beat(4, 5), 1'b0, 0, 0, 0, 0);
        directed_rows[14] = mk_row(read_beat(5, 11), 1'b0, 0, 0, 0, 0);
        for (k = 0; k < N_DIRECTED; k++)
            send_beat(directed_rows[k].beat, directed_rows[k].known, directed_rows[k].result);

        // With one bin per side every fill lands in the same bin and keeps adding to it.
        write_side(5'd1);
        for (k = 0; k < 3; k++) begin
            send_beat(fill_beat(1, 0, 0, 65535), 1'b0, '0);
        end

        // Random phases across sides and idling profiles.
        for (int ph = 0; ph < 6; ph++) begin
            write_side(sides[ph]);
            case (ph % 3)
                0: begin send_idle_pct = 38; recv_idle_pct = 50; end
                1: begin send_idle_pct = 50; recv_idle_pct = 38; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            if (ph == 2) begin
                fork
                    begin
                        hold_receiver = 1'b1;
                        repeat (300) @(negedge i_clk);
                        hold_receiver = 1'b0;
                    end
                join_none
            end
            for (k = 0; k < N_RANDOM / 6; k++) begin
                send_beat(random_beat(), 1'b0, '0);
                if (k == 100) wait_results();
            end
        end

        wait_drained();
        $display("covered %0d fills and %0d reads over six side settings, %0d results",
                 fills_sent, reads_sent, results_seen);
        if (mismatches == 0 && expected_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
